[sv/dts_pkg.sv]
// Shared types and constants for the delay token scanner.
`timescale 1ns / 1ps
`default_nettype none

package dts_pkg;

    localparam int OFF_W = 12;
    localparam int VAL_W = 32;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic                    found;
        logic [OFF_W-1:0]        token_offset;
        logic signed [VAL_W-1:0] delay_ms;
        logic                    value_saturated;
    } out_item_t;

    typedef enum logic [3:0] {
        CC_SPACE,
        CC_D,
        CC_E,
        CC_L,
        CC_A,
        CC_Y,
        CC_MINUS,
        CC_PLUS,
        CC_DIGIT,
        CC_M,
        CC_S,
        CC_DOT,
        CC_OTHER
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
        logic        is_last;
    } class_item_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_TOK1,
        PH_TOK2,
        PH_TOK3,
        PH_TOK4,
        PH_TOK5,
        PH_TOK6,
        PH_TOKEN,
        PH_SIGN,
        PH_DIGITS,
        PH_M,
        PH_MS
    } phase_t;

    // class expected next while " DELAY " is partly matched
    function automatic char_class_t tok_class(input phase_t ph);
        char_class_t c;
        begin
            case (ph)
                PH_IDLE: c = CC_SPACE;
                PH_TOK1: c = CC_D;
                PH_TOK2: c = CC_E;
                PH_TOK3: c = CC_L;
                PH_TOK4: c = CC_A;
                PH_TOK5: c = CC_Y;
                PH_TOK6: c = CC_SPACE;
                default: c = CC_OTHER;
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

[sv/dts_fifo.sv]
// Small register queue with a count, used between stages and at the output.
`timescale 1ns / 1ps
`default_nettype none

module dts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

[sv/dts_front.sv]
// Front end: classifies each accepted byte for the matcher.
`timescale 1ns / 1ps
`default_nettype none

module dts_front
    import dts_pkg::*;
(
    input  wire in_item_t item,
    output class_item_t   cls_item
);

    always_comb
    begin
        cls_item.is_last = item.is_last;
        cls_item.digit   = item.char_byte[3:0];
        if (item.char_byte >= 8'h30 && item.char_byte <= 8'h39)
        begin
            cls_item.cls = CC_DIGIT;
        end
        else
        begin
            case (item.char_byte)
                8'h20:   cls_item.cls = CC_SPACE;
                8'h44:   cls_item.cls = CC_D;
                8'h45:   cls_item.cls = CC_E;
                8'h4C:   cls_item.cls = CC_L;
                8'h41:   cls_item.cls = CC_A;
                8'h59:   cls_item.cls = CC_Y;
                8'h2D:   cls_item.cls = CC_MINUS;
                8'h2B:   cls_item.cls = CC_PLUS;
                8'h6D:   cls_item.cls = CC_M;
                8'h73:   cls_item.cls = CC_S;
                8'h2E:   cls_item.cls = CC_DOT;
                default: cls_item.cls = CC_OTHER;
            endcase
        end
    end

endmodule

`default_nettype wire

[sv/dts_back.sv]
// Back end: token matcher, value accumulator and winner tracking.
`timescale 1ns / 1ps
`default_nettype none

module dts_back
    import dts_pkg::*;
#(
    parameter int MAX_NAME_LEN = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire class_item_t cls_item,
    input  wire logic        cls_valid,
    output logic             cls_take,
    output out_item_t        res_item,
    output logic             res_push,
    input  wire logic        res_full
);

    localparam int IDX_W = $clog2(MAX_NAME_LEN);
    localparam logic [VAL_W:0] LIM_POS = (VAL_W+1)'(32'h7FFF_FFFF);
    localparam logic [VAL_W:0] LIM_NEG = (VAL_W+1)'(32'h8000_0000);

    phase_t           phase_reg, phase_next, phase_upd;
    logic [IDX_W-1:0] idx_reg, idx_next, idx_prev;
    logic [IDX_W-1:0] cand_off_reg, cand_off_next, cand_off_upd;
    logic             cand_neg_reg, cand_neg_next, cand_neg_upd;
    logic [VAL_W-1:0] accum_reg, accum_next, accum_upd;
    logic             acc_sat_reg, acc_sat_next, acc_sat_upd;
    logic             best_valid_reg, best_valid_next, best_valid_upd;
    logic [IDX_W-1:0] best_off_reg, best_off_next, best_off_upd;
    logic [VAL_W-1:0] best_val_reg, best_val_next, best_val_upd;
    logic             best_sat_reg, best_sat_next, best_sat_upd;
    logic [VAL_W+3:0] acc_trial;
    logic [VAL_W:0]   acc_limit;
    logic             step;
    logic             do_commit;
    logic [IDX_W+OFF_W-1:0] off_ext;

    assign cls_take = cls_valid && !res_full;
    assign step     = cls_take;
    assign idx_prev = (idx_reg == '0) ? IDX_W'(MAX_NAME_LEN - 1) : idx_reg - 1'b1;

    assign acc_trial = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                     + {{VAL_W{1'b0}}, cls_item.digit};
    assign acc_limit = cand_neg_reg ? LIM_NEG : LIM_POS;

    // next state of the matcher and its datapath
    always_comb
    begin
        phase_upd    = phase_reg;
        cand_off_upd = cand_off_reg;
        cand_neg_upd = cand_neg_reg;
        accum_upd    = accum_reg;
        acc_sat_upd  = acc_sat_reg;
        do_commit    = 1'b0;

        case (phase_reg)
            PH_IDLE, PH_TOK1, PH_TOK2, PH_TOK3, PH_TOK4, PH_TOK5, PH_TOK6:
            begin
                if (cls_item.cls == tok_class(phase_reg) && phase_reg != PH_IDLE)
                begin
                    phase_upd = phase_t'(phase_reg + 1'b1);
                end
                else if (cls_item.cls == CC_SPACE)
                begin
                    phase_upd    = PH_TOK1;
                    cand_off_upd = idx_reg;
                    cand_neg_upd = 1'b0;
                    accum_upd    = '0;
                    acc_sat_upd  = 1'b0;
                end
                else
                begin
                    phase_upd = PH_IDLE;
                end
            end
            PH_TOKEN, PH_SIGN, PH_DIGITS:
            begin
                if (phase_reg == PH_TOKEN
                    && (cls_item.cls == CC_MINUS || cls_item.cls == CC_PLUS))
                begin
                    cand_neg_upd = (cls_item.cls == CC_MINUS);
                    phase_upd    = PH_SIGN;
                end
                else if (cls_item.cls == CC_DIGIT)
                begin
                    phase_upd = PH_DIGITS;
                    if (acc_trial > {3'b000, acc_limit})
                    begin
                        accum_upd   = acc_limit[VAL_W-1:0];
                        acc_sat_upd = 1'b1;
                    end
                    else
                    begin
                        accum_upd = acc_trial[VAL_W-1:0];
                    end
                end
                else if (phase_reg == PH_TOKEN && cls_item.cls == CC_D)
                begin
                    // trailing space of the token opens a new candidate
                    phase_upd    = PH_TOK2;
                    cand_off_upd = idx_prev;
                    cand_neg_upd = 1'b0;
                    accum_upd    = '0;
                    acc_sat_upd  = 1'b0;
                end
                else if (phase_reg == PH_DIGITS && cls_item.cls == CC_M)
                begin
                    phase_upd = PH_M;
                end
                else if (cls_item.cls == CC_SPACE)
                begin
                    phase_upd    = PH_TOK1;
                    cand_off_upd = idx_reg;
                    cand_neg_upd = 1'b0;
                    accum_upd    = '0;
                    acc_sat_upd  = 1'b0;
                end
                else
                begin
                    phase_upd = PH_IDLE;
                end
            end
            PH_M, PH_MS:
            begin
                if (phase_reg == PH_M && cls_item.cls == CC_S)
                begin
                    phase_upd = PH_MS;
                    do_commit = cls_item.is_last;
                end
                else if (phase_reg == PH_MS && cls_item.cls == CC_DOT)
                begin
                    do_commit = 1'b1;
                end
                else if (cls_item.cls == CC_SPACE)
                begin
                    phase_upd    = PH_TOK1;
                    cand_off_upd = idx_reg;
                    cand_neg_upd = 1'b0;
                    accum_upd    = '0;
                    acc_sat_upd  = 1'b0;
                end
                else
                begin
                    phase_upd = PH_IDLE;
                end
            end
            default:
            begin
                phase_upd = PH_IDLE;
            end
        endcase

        if (do_commit)
        begin
            phase_upd = PH_IDLE;
        end
        best_valid_upd = best_valid_reg || do_commit;
        best_off_upd   = do_commit ? cand_off_reg : best_off_reg;
        best_val_upd   = do_commit ? (cand_neg_reg ? (VAL_W'(0) - accum_reg) : accum_reg)
                                   : best_val_reg;
        best_sat_upd   = do_commit ? acc_sat_reg : best_sat_reg;

        phase_next      = phase_reg;
        idx_next        = idx_reg;
        cand_off_next   = cand_off_reg;
        cand_neg_next   = cand_neg_reg;
        accum_next      = accum_reg;
        acc_sat_next    = acc_sat_reg;
        best_valid_next = best_valid_reg;
        best_off_next   = best_off_reg;
        best_val_next   = best_val_reg;
        best_sat_next   = best_sat_reg;
        if (step)
        begin
            if (cls_item.is_last)
            begin
                phase_next      = PH_IDLE;
                idx_next        = '0;
                cand_off_next   = '0;
                cand_neg_next   = 1'b0;
                accum_next      = '0;
                acc_sat_next    = 1'b0;
                best_valid_next = 1'b0;
                best_off_next   = '0;
                best_val_next   = '0;
                best_sat_next   = 1'b0;
            end
            else
            begin
                phase_next      = phase_upd;
                idx_next        = (idx_reg == IDX_W'(MAX_NAME_LEN - 1)) ? '0
                                                                         : idx_reg + 1'b1;
                cand_off_next   = cand_off_upd;
                cand_neg_next   = cand_neg_upd;
                accum_next      = accum_upd;
                acc_sat_next    = acc_sat_upd;
                best_valid_next = best_valid_upd;
                best_off_next   = best_off_upd;
                best_val_next   = best_val_upd;
                best_sat_next   = best_sat_upd;
            end
        end
    end

    // result item on the last byte
    always_comb
    begin
        off_ext                  = {{OFF_W{1'b0}}, best_off_upd};
        res_push                 = step && cls_item.is_last;
        res_item.found           = best_valid_upd;
        res_item.token_offset    = best_valid_upd ? off_ext[OFF_W-1:0] : '0;
        res_item.delay_ms        = best_valid_upd ? best_val_upd : '0;
        res_item.value_saturated = best_valid_upd && best_sat_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            idx_reg        <= '0;
            cand_off_reg   <= '0;
            cand_neg_reg   <= 1'b0;
            accum_reg      <= '0;
            acc_sat_reg    <= 1'b0;
            best_valid_reg <= 1'b0;
            best_off_reg   <= '0;
            best_val_reg   <= '0;
            best_sat_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            cand_off_reg   <= cand_off_next;
            cand_neg_reg   <= cand_neg_next;
            accum_reg      <= accum_next;
            acc_sat_reg    <= acc_sat_next;
            best_valid_reg <= best_valid_next;
            best_off_reg   <= best_off_next;
            best_val_reg   <= best_val_next;
            best_sat_reg   <= best_sat_next;
        end
    end

endmodule

`default_nettype wire

[sv/delay_token_scanner.sv]
// A byte accepted into the first queue is matched at the queue head while the result queue is not
// full; matching a name's last byte also loads the name's result into the output queue.
// Throughput: one byte per clock unless the result queue is full, set by the matcher and times-ten accumulate.
// A two-entry queue sits between classifier and matcher, another holds finished results.
// Reset (rst_n low, asynchronous) empties both queues and clears all match state.
`timescale 1ns / 1ps
`default_nettype none

module delay_token_scanner
    import dts_pkg::*;
#(
    parameter int MAX_NAME_LEN = 4096
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire in_item_t  item,
    output logic           empty,
    input  wire logic      pop,
    output out_item_t      result
);

    localparam int CLS_W = $bits(class_item_t);
    localparam int RES_W = $bits(out_item_t);

    class_item_t cls_in;
    class_item_t cls_out;
    logic        mid_empty;
    logic        mid_take;
    out_item_t   res_item;
    logic        res_push;
    logic        res_full;

    dts_front u_front (
        .item     (item),
        .cls_item (cls_in)
    );

    dts_fifo #(
        .WIDTH (CLS_W),
        .DEPTH (2)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls_in),
        .full  (full),
        .pop   (mid_take),
        .rdata (cls_out),
        .empty (mid_empty)
    );

    dts_back #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_item  (cls_out),
        .cls_valid (!mid_empty),
        .cls_take  (mid_take),
        .res_item  (res_item),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    dts_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_item),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

`default_nettype wire

[test/tb_delay_token_scanner.sv]
// Self-checking testbench for the delay token scanner: directed names, then random names.
`timescale 1ns / 1ps

module tb_delay_token_scanner;

    import dts_pkg::*;

    typedef struct {
        string text;
        bit    typed;
        bit    found;
        int    offset;
        int    value;
        bit    sat;
    } dir_row_t;

    localparam int DIR_ROWS = 16;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{"x",                        1, 0, 0, 0,            0},
        '{" ",                        1, 0, 0, 0,            0},
        '{"DELAY 4ms",                1, 0, 0, 0,            0},
        '{" DELAY 5ms",               1, 1, 0, 5,            0},
        '{" DELAY +12ms.wav",         1, 1, 0, 12,           0},
        '{" DELAY -2147483648ms.mkv", 1, 1, 0, 32'h8000_0000, 0},
        '{" DELAY 2147483647ms",      1, 1, 0, 32'h7FFF_FFFF, 0},
        '{" DELAY 2147483648ms",      1, 1, 0, 32'h7FFF_FFFF, 1},
        '{"a DELAY -99999999999ms",   1, 1, 1, 32'h8000_0000, 1},
        '{" DELAY -ms",               1, 0, 0, 0,            0},
        '{" DELAY 12",                1, 0, 0, 0,            0},
        '{" DELAY 12msx",             1, 0, 0, 0,            0},
        '{" DELAY 12ms DELAY 3m",     0, 0, 0, 0,            0},
        '{" DELAY DELAY 3ms.ac3",     0, 0, 0, 0,            0},
        '{"a DELAY 1ms. DELAY 2ms",   0, 0, 0, 0,            0},
        '{"  DEL DELAY 007ms",        0, 0, 0, 0,            0}
    };

    logic      clk;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      pop   = 1'b0;
    in_item_t  item  = '0;
    logic      full;
    logic      empty;
    out_item_t result;

    // scanner state as predicted
    phase_t      scan_phase;
    logic [11:0] scan_index;
    logic [11:0] cand_start;
    logic        cand_minus;
    logic [31:0] cand_mag;
    logic        cand_clamped;
    logic        best_seen;
    logic [11:0] best_start;
    logic [31:0] best_ms;
    logic        best_clamped;

    out_item_t   awaited_reports [$];
    logic [7:0]  name_bytes [$];

    bit          use_typed;
    out_item_t   typed_want;
    bit          calm;
    bit          lazy;
    bit          stall_req;
    int          errors;

    delay_token_scanner i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [7:0] token_char(input phase_t ph);
        case (ph)
            PH_TOK1: return "D";
            PH_TOK2: return "E";
            PH_TOK3: return "L";
            PH_TOK4: return "A";
            PH_TOK5: return "Y";
            default: return " ";
        endcase
    endfunction

    task automatic clear_scan();
        scan_index   = '0;
        scan_phase   = PH_IDLE;
        cand_start   = '0;
        cand_minus   = 1'b0;
        cand_mag     = '0;
        cand_clamped = 1'b0;
        best_seen    = 1'b0;
        best_start   = '0;
        best_ms      = '0;
        best_clamped = 1'b0;
    endtask

    task automatic open_cand(input logic [11:0] at, input phase_t ph);
        cand_start   = at;
        scan_phase   = ph;
        cand_minus   = 1'b0;
        cand_mag     = '0;
        cand_clamped = 1'b0;
    endtask

    task automatic drop_cand(input logic [7:0] c);
        if (c == " ")
            open_cand(scan_index, PH_TOK1);
        else
            scan_phase = PH_IDLE;
    endtask

    task automatic take_digit(input logic [7:0] c);
        logic [35:0] lim;
        logic [35:0] t;
        lim = cand_minus ? 36'h0_8000_0000 : 36'h0_7FFF_FFFF;
        t = 36'(cand_mag) * 36'd10 + 36'(c - 8'h30);
        if (t > lim)
        begin
            t = lim;
            cand_clamped = 1'b1;
        end
        cand_mag   = t[31:0];
        scan_phase = PH_DIGITS;
    endtask

    task automatic keep_cand();
        best_seen    = 1'b1;
        best_start   = cand_start;
        best_ms      = cand_minus ? 32'd0 - cand_mag : cand_mag;
        best_clamped = cand_clamped;
        scan_phase   = PH_IDLE;
    endtask

    task automatic scan_byte(input logic [7:0] c, input logic last,
                             output bit done, output out_item_t r);
        bit is_dig;
        is_dig = c >= "0" && c <= "9";
        done   = 1'b0;
        r      = '0;
        if (scan_phase <= PH_TOK6)
        begin
            if (c == token_char(scan_phase))
            begin
                if (scan_phase == PH_IDLE)
                    open_cand(scan_index, PH_TOK1);
                else
                    scan_phase = phase_t'(scan_phase + 1);
            end
            else
                drop_cand(c);
        end
        else if (scan_phase == PH_TOKEN)
        begin
            if (c == "-" || c == "+")
            begin
                cand_minus = (c == "-");
                scan_phase = PH_SIGN;
            end
            else if (is_dig)
                take_digit(c);
            else if (c == "D")
                open_cand(scan_index - 12'd1, PH_TOK2);
            else
                drop_cand(c);
        end
        else if (scan_phase == PH_SIGN)
        begin
            if (is_dig)
                take_digit(c);
            else
                drop_cand(c);
        end
        else if (scan_phase == PH_DIGITS)
        begin
            if (is_dig)
                take_digit(c);
            else if (c == "m")
                scan_phase = PH_M;
            else
                drop_cand(c);
        end
        else if (scan_phase == PH_M)
        begin
            if (c == "s")
            begin
                scan_phase = PH_MS;
                if (last)
                    keep_cand();
            end
            else
                drop_cand(c);
        end
        else
        begin
            if (c == ".")
                keep_cand();
            else
                drop_cand(c);
        end
        scan_index = scan_index + 12'd1;
        if (last)
        begin
            done              = 1'b1;
            r.found           = best_seen;
            r.token_offset    = best_seen ? best_start : '0;
            r.delay_ms        = best_seen ? best_ms : '0;
            r.value_saturated = best_seen & best_clamped;
            clear_scan();
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic send_byte(input logic [7:0] c, input logic last);
        bit        done;
        out_item_t r;
        item <= '{char_byte: c, is_last: last};
        push <= 1'b1;
        do
            @(posedge clk);
        while (full);
        scan_byte(c, last, done, r);
        if (done)
        begin
            if (use_typed)
                awaited_reports = {awaited_reports, typed_want};
            else
                awaited_reports = {awaited_reports, r};
        end
        if (!calm && lazy && $urandom_range(0, 11) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic send_name();
        for (int i = 0; i < name_bytes.size(); i++)
            send_byte(name_bytes[i], i == name_bytes.size() - 1);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            name_bytes = {name_bytes, s[i]};
    endtask

    task automatic build_name();
        string      pool;
        string      tok_txt;
        logic [7:0] tok_q [$];
        int         segs;
        int         n;
        pool = " DELAYms.+-0123456789xD";
        tok_txt = " DELAY ";
        name_bytes.delete();
        segs = $urandom_range(1, 4);
        for (int k = 0; k < segs; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    n = $urandom_range(0, 6);
                    repeat (n) name_bytes = {name_bytes, 8'($urandom_range(0, 255))};
                end
                2:
                begin
                    n = $urandom_range(1, 8);
                    repeat (n)
                        name_bytes = {name_bytes, pool[$urandom_range(0, pool.len() - 1)]};
                end
                default:
                begin
                    tok_q.delete();
                    for (int i = 0; i < tok_txt.len(); i++)
                        tok_q = {tok_q, tok_txt[i]};
                    case ($urandom_range(0, 3))
                        0: tok_q = {tok_q, 8'h2D};
                        1: tok_q = {tok_q, 8'h2B};
                        default: ;
                    endcase
                    n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12)
                                                    : $urandom_range(1, 5);
                    repeat (n) tok_q = {tok_q, 8'(8'h30 + $urandom_range(0, 9))};
                    tok_q = {tok_q, 8'h6D, 8'h73};
                    if ($urandom_range(0, 1) == 0)
                        tok_q = {tok_q, 8'h2E};
                    if ($urandom_range(0, 4) == 0)
                        tok_q[$urandom_range(0, tok_q.size() - 1)] = 8'($urandom_range(0, 255));
                    foreach (tok_q[i])
                        name_bytes = {name_bytes, tok_q[i]};
                end
            endcase
        end
        if (name_bytes.size() == 0)
            name_bytes = {name_bytes, 8'($urandom_range(0, 255))};
    endtask

    // receiver side: checks and pop pacing
    initial
    begin
        int        hold;
        bit        rx_lazy;
        out_item_t want;
        hold    = 0;
        rx_lazy = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (awaited_reports.size() == 0)
                    report_mismatch("unexpected item", result.delay_ms, 0);
                else
                begin
                    want = awaited_reports.pop_front();
                    if (result.found != want.found)
                        report_mismatch("found", result.found, want.found);
                    if (result.token_offset != want.token_offset)
                        report_mismatch("token_offset", result.token_offset,
                                        want.token_offset);
                    if (result.delay_ms != want.delay_ms)
                        report_mismatch("delay_ms", result.delay_ms, want.delay_ms);
                    if (result.value_saturated != want.value_saturated)
                        report_mismatch("value_saturated", result.value_saturated,
                                        want.value_saturated);
                end
            end
            if ($urandom_range(0, 199) == 0)
                rx_lazy = !rx_lazy;
            if (stall_req)
            begin
                stall_req = 1'b0;
                pop <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (hold > 0)
            begin
                hold--;
                pop <= 1'b0;
            end
            else if (!calm && rx_lazy && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 17) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // sender side and end of run
    initial
    begin
        int sent;
        bit stall_done;
        errors     = 0;
        calm       = 1'b0;
        lazy       = 1'b1;
        stall_req  = 1'b0;
        stall_done = 1'b0;
        use_typed  = 1'b0;
        clear_scan();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            name_bytes.delete();
            add_text(dir_tab[r].text);
            use_typed                  = dir_tab[r].typed;
            typed_want.found           = dir_tab[r].found;
            typed_want.token_offset    = dir_tab[r].offset[11:0];
            typed_want.delay_ms        = dir_tab[r].value;
            typed_want.value_saturated = dir_tab[r].sat;
            send_name();
        end
        use_typed = 1'b0;

        sent = 0;
        while (sent < 780)
        begin
            build_name();
            lazy = $urandom_range(0, 2) != 0;
            if (!stall_done && sent >= 250)
            begin
                stall_done = 1'b1;
                stall_req  = 1'b1;
                lazy       = 1'b0;
            end
            if (sent >= 650)
                calm = 1'b1;
            sent += name_bytes.size();
            send_name();
        end
        push <= 1'b0;

        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
